// ----- hw/rtl/weighted_neighborhood_sum_5x5_unit_assert.svh -----
// Assertion macros for the weighted neighborhood sum unit.
// Expects clk and rst_n in the scope of use.
`ifndef WEIGHTED_NEIGHBORHOOD_SUM_5X5_UNIT_ASSERT_SVH
`define WEIGHTED_NEIGHBORHOOD_SUM_5X5_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define WNS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds after the antecedent, as a non-overlapping implication
`define WNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wns_pkg.sv -----
// Shared constants, types and register codes of the weighted neighborhood sum unit.
// No dependencies.
`default_nettype none

package wns_pkg;

    localparam int MAX_SIZE   = 1024;
    localparam int CNT_W      = $clog2(MAX_SIZE);
    localparam int SIZE_W     = CNT_W + 1;
    localparam int MIN_GRID   = 5;
    localparam int WIN        = 5;
    localparam int HALF       = 2;
    localparam int WIN_EDGE   = WIN - 1;
    localparam int LS_BANKS   = 4;
    localparam int BANK_W     = $clog2(LS_BANKS);
    localparam int DATA_W     = 32;
    localparam int WGT_W      = 16;
    localparam int NUM_CLS    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = Q_PTR_W + 1;

    localparam int CLS_CENTER   = 0;
    localparam int CLS_AXIAL1   = 1;
    localparam int CLS_DIAGONAL = 2;
    localparam int CLS_AXIAL2   = 3;
    localparam int CLS_KNIGHT_A = 4;
    localparam int CLS_KNIGHT_B = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE  = 3'd0,
        REG_W_CENTER   = 3'd1,
        REG_W_AXIAL1   = 3'd2,
        REG_W_DIAGONAL = 3'd3,
        REG_W_AXIAL2   = 3'd4,
        REG_W_KNIGHT_A = 3'd5,
        REG_W_KNIGHT_B = 3'd6
    } reg_idx_t;

    typedef logic [NUM_CLS-1:0][WGT_W-1:0] weight_set_t;

    typedef struct packed {
        logic [NUM_CLS-1:0][DATA_W-1:0] cls_sum;
        logic [CNT_W-1:0]               cx;
        logic [CNT_W-1:0]               cy;
        logic                           last;
    } job_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [CNT_W-1:0]  cx;
        logic [CNT_W-1:0]  cy;
        logic              last;
    } result_t;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/weighted_neighborhood_sum_5x5_unit.sv -----
// Top level of the weighted 5x5 neighborhood sum unit: configuration registers,
// front part, job queue and back part. Depends on wns_pkg, wns_front,
// wns_job_queue and wns_back.
//
//  Channel  | Handshake                 | Word
//  ---------+---------------------------+------------------------------------------
//  input    | push / full               | cell_value, first_of_grid
//  result   | empty / pop               | weighted_sum, center_x, center_y, last_result
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One cell is accepted per cycle while full is low; a result passes through two
// front stages, the job queue and three back stages before it appears.
// full rises once queued plus in-flight results reach the job queue depth;
// the back part drains the job queue only while the result queue has room.
// Reset clears counters, queue pointers and configuration registers; the line store and data registers are not cleared.
// cfg_ready is always high.
`default_nettype none

module weighted_neighborhood_sum_5x5_unit
    import wns_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic signed [DATA_W-1:0] cell_value,
    input  logic                  first_of_grid,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [DATA_W-1:0] weighted_sum,
    output logic [CNT_W-1:0]      center_x,
    output logic [CNT_W-1:0]      center_y,
    output logic                  last_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIZE_W-1:0] grid_size_reg;
    weight_set_t       weight_reg;

    logic              job_push, job_pop;
    job_t              job_in, job_out;
    q_stat_t           q_stat;
    logic [DATA_W-1:0] sum_bits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= SIZE_W'(MIN_GRID);
            weight_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GRID_SIZE:  grid_size_reg <= cfg_data[SIZE_W-1:0];
                REG_W_CENTER:   weight_reg[CLS_CENTER]   <= cfg_data;
                REG_W_AXIAL1:   weight_reg[CLS_AXIAL1]   <= cfg_data;
                REG_W_DIAGONAL: weight_reg[CLS_DIAGONAL] <= cfg_data;
                REG_W_AXIAL2:   weight_reg[CLS_AXIAL2]   <= cfg_data;
                REG_W_KNIGHT_A: weight_reg[CLS_KNIGHT_A] <= cfg_data;
                REG_W_KNIGHT_B: weight_reg[CLS_KNIGHT_B] <= cfg_data;
                default:        ;
            endcase
        end
    end

    wns_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cell_value    (cell_value),
        .first_of_grid (first_of_grid),
        .grid_size     (grid_size_reg),
        .q_stat        (q_stat),
        .job_push      (job_push),
        .job           (job_in)
    );

    wns_job_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .pop   (job_pop),
        .dout  (job_out),
        .stat  (q_stat)
    );

    wns_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .job          (job_out),
        .job_pop      (job_pop),
        .weights      (weight_reg),
        .pop          (pop),
        .empty        (empty),
        .weighted_sum (sum_bits),
        .center_x     (center_x),
        .center_y     (center_y),
        .last_result  (last_result)
    );

    assign weighted_sum = signed'(sum_bits);

endmodule

`default_nettype wire

// ----- hw/rtl/wns_front.sv -----
// Front part: raster counters, four-bank line store, 5x5 window and class sums.
// Depends on wns_pkg; feeds wns_job_queue.
`default_nettype none

module wns_front
    import wns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [DATA_W-1:0] cell_value,
    input  logic              first_of_grid,
    input  logic [SIZE_W-1:0] grid_size,
    input  q_stat_t           q_stat,
    output logic              job_push,
    output job_t              job
);

    logic [CNT_W-1:0]  col_reg, row_reg, col_next, row_next;
    logic [CNT_W-1:0]  x_base, y_base, x_cur, y_cur;
    logic [SIZE_W-1:0] size_use, x_inc, y_inc;
    logic              accept, emit_cur, last_cur;

    logic              v1_reg, emit1_reg, last1_reg;
    logic [DATA_W-1:0] cell1_reg;
    logic [BANK_W-1:0] ysel1_reg;
    logic [CNT_W-1:0]  cx1_reg, cy1_reg;

    logic              v2_reg, last2_reg;
    logic [CNT_W-1:0]  cx2_reg, cy2_reg;

    logic [DATA_W-1:0] rd_data [LS_BANKS];
    logic [DATA_W-1:0] win_reg [WIN][WIN];
    logic [Q_CNT_W:0]  reserved;

    assign reserved = {1'b0, q_stat.count} + (Q_CNT_W+1)'(v1_reg & emit1_reg)
                      + (Q_CNT_W+1)'(v2_reg);
    assign full     = reserved >= (Q_CNT_W+1)'(Q_DEPTH);
    assign accept   = push & ~full;

    always_comb
    begin
        size_use = grid_size;
        if (grid_size < SIZE_W'(MIN_GRID))
        begin
            size_use = SIZE_W'(MIN_GRID);
        end
        else if (grid_size > SIZE_W'(MAX_SIZE))
        begin
            size_use = SIZE_W'(MAX_SIZE);
        end
        x_base = first_of_grid ? '0 : col_reg;
        y_base = first_of_grid ? '0 : row_reg;
        x_cur  = ({1'b0, x_base} >= size_use) ? '0 : x_base;
        y_cur  = ({1'b0, y_base} >= size_use) ? '0 : y_base;
        x_inc  = {1'b0, x_cur} + SIZE_W'(1);
        y_inc  = {1'b0, y_cur} + SIZE_W'(1);
        if (x_inc >= size_use)
        begin
            col_next = '0;
            row_next = (y_inc >= size_use) ? '0 : y_inc[CNT_W-1:0];
        end
        else
        begin
            col_next = x_inc[CNT_W-1:0];
            row_next = y_cur;
        end
        emit_cur = (x_cur >= CNT_W'(WIN_EDGE)) && (y_cur >= CNT_W'(WIN_EDGE));
        last_cur = ({1'b0, x_cur} == size_use - SIZE_W'(1))
                   && ({1'b0, y_cur} == size_use - SIZE_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store: one bank per line, read before write at the same column
    for (genvar b = 0; b < LS_BANKS; b++)
    begin : g_bank
        logic [DATA_W-1:0] mem [MAX_SIZE];
        logic [DATA_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                rd_reg <= mem[x_cur];
                if (y_cur[BANK_W-1:0] == BANK_W'(b))
                begin
                    mem[x_cur] <= cell_value;
                end
            end
        end

        assign rd_data[b] = rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            emit1_reg <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            v1_reg    <= accept;
            emit1_reg <= accept & emit_cur;
            v2_reg    <= v1_reg & emit1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell1_reg <= cell_value;
            ysel1_reg <= y_cur[BANK_W-1:0];
            cx1_reg   <= x_cur - CNT_W'(HALF);
            cy1_reg   <= y_cur - CNT_W'(HALF);
            last1_reg <= last_cur;
        end
        if (v1_reg)
        begin
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            last2_reg <= last1_reg;
        end
    end

    // shift window left, load new right column
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN_EDGE; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            for (int r = 0; r < WIN_EDGE; r++)
            begin
                win_reg[r][WIN_EDGE] <= rd_data[BANK_W'(ysel1_reg + BANK_W'(r))];
            end
            win_reg[WIN_EDGE][WIN_EDGE] <= cell1_reg;
        end
    end

    assign job_push = v2_reg;

    always_comb
    begin
        job.cls_sum[CLS_CENTER]   = win_reg[2][2];
        job.cls_sum[CLS_AXIAL1]   = win_reg[2][3] + win_reg[2][1]
                                    + win_reg[3][2] + win_reg[1][2];
        job.cls_sum[CLS_DIAGONAL] = win_reg[3][3] + win_reg[1][3]
                                    + win_reg[3][1] + win_reg[1][1];
        job.cls_sum[CLS_AXIAL2]   = win_reg[2][4] + win_reg[2][0]
                                    + win_reg[4][2] + win_reg[0][2];
        job.cls_sum[CLS_KNIGHT_A] = win_reg[4][1] + win_reg[0][3]
                                    + win_reg[3][4] + win_reg[1][0];
        job.cls_sum[CLS_KNIGHT_B] = win_reg[4][3] + win_reg[0][1]
                                    + win_reg[1][4] + win_reg[3][0];
        job.cx   = cx2_reg;
        job.cy   = cy2_reg;
        job.last = last2_reg;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wns_job_queue.sv -----
// Short queue of class-sum words between the front and back parts.
// Depends on wns_pkg.
`default_nettype none

module wns_job_queue
    import wns_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    din,
    input  logic    pop,
    output job_t    dout,
    output q_stat_t stat
);

    job_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_pop;

    assign do_pop = pop & (cnt_reg != '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.count = cnt_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wns_back.sv -----
// Back part: weighted products, adder stages and the result queue.
// Depends on wns_pkg; drains wns_job_queue.
`default_nettype none

module wns_back
    import wns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_stat_t           q_stat,
    input  job_t              job,
    output logic              job_pop,
    input  weight_set_t       weights,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] weighted_sum,
    output logic [CNT_W-1:0]  center_x,
    output logic [CNT_W-1:0]  center_y,
    output logic              last_result
);

    logic [DATA_W-1:0]  w_ext     [NUM_CLS];
    logic [DATA_W-1:0]  prod_next [NUM_CLS];
    logic [DATA_W-1:0]  prod_reg  [NUM_CLS];
    logic [DATA_W-1:0]  part_reg  [2];
    logic               b1_v_reg, b2_v_reg, b1_last_reg, b2_last_reg;
    logic [CNT_W-1:0]   b1_cx_reg, b1_cy_reg, b2_cx_reg, b2_cy_reg;

    result_t            out_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] out_wr_reg, out_rd_reg;
    logic [Q_CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [Q_CNT_W:0]   reserved;
    logic               out_pop;
    result_t            head;

    assign reserved = {1'b0, out_cnt_reg} + (Q_CNT_W+1)'(b1_v_reg)
                      + (Q_CNT_W+1)'(b2_v_reg);
    assign job_pop  = ~q_stat.empty & (reserved < (Q_CNT_W+1)'(Q_DEPTH));
    assign out_pop  = pop & ~empty;

    // drop a class whose weight is not positive; the center always counts
    always_comb
    begin
        for (int k = 0; k < NUM_CLS; k++)
        begin
            w_ext[k] = DATA_W'(signed'(weights[k]));
            if (k == CLS_CENTER || (!weights[k][WGT_W-1] && weights[k] != '0))
            begin
                prod_next[k] = w_ext[k] * job.cls_sum[k];
            end
            else
            begin
                prod_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
        end
        else
        begin
            b1_v_reg <= job_pop;
            b2_v_reg <= b1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            for (int k = 0; k < NUM_CLS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            b1_cx_reg   <= job.cx;
            b1_cy_reg   <= job.cy;
            b1_last_reg <= job.last;
        end
        if (b1_v_reg)
        begin
            part_reg[0] <= prod_reg[0] + prod_reg[1] + prod_reg[2];
            part_reg[1] <= prod_reg[3] + prod_reg[4] + prod_reg[5];
            b2_cx_reg   <= b1_cx_reg;
            b2_cy_reg   <= b1_cy_reg;
            b2_last_reg <= b1_last_reg;
        end
        if (b2_v_reg)
        begin
            out_mem[out_wr_reg].sum  <= part_reg[0] + part_reg[1];
            out_mem[out_wr_reg].cx   <= b2_cx_reg;
            out_mem[out_wr_reg].cy   <= b2_cy_reg;
            out_mem[out_wr_reg].last <= b2_last_reg;
        end
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (b2_v_reg && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + Q_CNT_W'(1);
        end
        else if (!b2_v_reg && out_pop)
        begin
            out_cnt_next = out_cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (b2_v_reg)
            begin
                out_wr_reg <= out_wr_reg + Q_PTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + Q_PTR_W'(1);
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    assign head         = out_mem[out_rd_reg];
    assign empty        = (out_cnt_reg == '0);
    assign weighted_sum = head.sum;
    assign center_x     = head.cx;
    assign center_y     = head.cy;
    assign last_result  = head.last;

endmodule

`default_nettype wire

// ----- hw/rtl/weighted_neighborhood_sum_5x5_unit_chk.sv -----
// Port-level checker for the weighted neighborhood sum unit, bound to the top level.
// Depends on wns_pkg and weighted_neighborhood_sum_5x5_unit_assert.svh.
`default_nettype none

`include "weighted_neighborhood_sum_5x5_unit_assert.svh"

module weighted_neighborhood_sum_5x5_unit_chk
    import wns_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic [DATA_W-1:0] weighted_sum,
    input logic [CNT_W-1:0]  center_x,
    input logic [CNT_W-1:0]  center_y,
    input logic              last_result
);

    `WNS_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(weighted_sum) && $stable(center_x) && $stable(center_y), "waiting result changed before pop")
    `WNS_ASSERT_ALWAYS(a_center_interior, empty || (center_x >= CNT_W'(HALF) && center_y >= CNT_W'(HALF)), "result center on the border")
    `WNS_ASSERT_ALWAYS(a_last_on_diagonal, empty || !last_result || center_x == center_y, "last result off the grid corner")

endmodule

bind weighted_neighborhood_sum_5x5_unit weighted_neighborhood_sum_5x5_unit_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .weighted_sum (weighted_sum),
    .center_x     (center_x),
    .center_y     (center_y),
    .last_result  (last_result)
);

`default_nettype wire
